>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line position checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Types, widths and helpers shared by the line position centroid modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

   // Number of sensors in use (2 to 8). Widths below are sized for eight.
   localparam int SENSOR_COUNT = 8;
   localparam int SPAN         = SENSOR_COUNT - 1;

   localparam int SAMPLE_W = 12;
   localparam int WSUM_W   = 15;  // 8 * 4095 fits
   localparam int ISUM_W   = 17;  // 28 * 4095 fits
   localparam int DEN_W    = 18;  // 7 * 32760 fits
   localparam int DIFF_W   = DEN_W + 1;
   localparam int REM_W    = 31;  // 5120 * den + den fits
   localparam int Q_W      = 12;  // quotient magnitude at most 2560
   localparam int POS_W    = 13;

   // Position scale: 2 * 10 * 256 and 10 * 256.
   localparam int POS_SCALE = 2 * 10 * 256;

   localparam int PIPE_DEPTH = Q_W + 4;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = SAMPLE_W'(2500);

   typedef logic [SAMPLE_W-1:0]      sample_type;
   typedef logic [WSUM_W-1:0]        wsum_type;
   typedef logic [ISUM_W-1:0]        isum_type;
   typedef logic [DEN_W-1:0]         den_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic [REM_W-1:0]         rem_type;
   typedef logic [Q_W-1:0]           quo_type;
   typedef logic signed [POS_W-1:0]  pos_type;

   typedef struct packed {
      sample_type sample_0;
      sample_type sample_1;
      sample_type sample_2;
      sample_type sample_3;
      sample_type sample_4;
      sample_type sample_5;
      sample_type sample_6;
      sample_type sample_7;
   } req_item_type;

   typedef struct packed {
      pos_type position;
      logic    line_lost;
   } rsp_item_type;

   // State carried through the divider chain.
   typedef struct packed {
      rem_type rem;
      rem_type dsr;
      quo_type quo;
      logic    neg;
      logic    lost;
   } div_type;

   function automatic sample_type sample_of(req_item_type item, int idx);
      sample_type s;
      unique case (idx)
         0: s = item.sample_0;
         1: s = item.sample_1;
         2: s = item.sample_2;
         3: s = item.sample_3;
         4: s = item.sample_4;
         5: s = item.sample_5;
         6: s = item.sample_6;
         7: s = item.sample_7;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/lpc_lane.sv
// ----------------------------------------------------------------------------
// lpc_lane
// One sensor lane: clamps the sample and registers its weight.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_lane (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire lpc_pkg::sample_type full_scale,
   input  wire lpc_pkg::sample_type sample,
   output lpc_pkg::sample_type      weight
);

   lpc_pkg::sample_type weight_ff;
   lpc_pkg::sample_type weight_in;

   // A sample above full scale carries no weight.
   always_comb begin
      weight_in = (sample > full_scale) ? '0 : full_scale - sample;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpc_merge.sv
// ----------------------------------------------------------------------------
// lpc_merge
// Sums the lane weights and sets up the rounding division.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_merge (
   input  wire logic                                       clock,
   input  wire logic                                       advance,
   input  wire lpc_pkg::sample_type [lpc_pkg::SENSOR_COUNT-1:0] weights,
   output lpc_pkg::div_type                                div_init
);

   lpc_pkg::wsum_type wsum_ff, wsum_in;
   lpc_pkg::isum_type isum_ff, isum_in;
   lpc_pkg::div_type  div_ff, div_in;

   lpc_pkg::den_type  den;
   lpc_pkg::diff_type diff;
   lpc_pkg::den_type  mag;

   always_comb begin
      wsum_in = '0;
      isum_in = '0;
      for (int i = 0; i < lpc_pkg::SENSOR_COUNT; i++) begin
         wsum_in = wsum_in + lpc_pkg::wsum_type'(weights[i]);
         isum_in = isum_in + lpc_pkg::isum_type'(weights[i]) * lpc_pkg::isum_type'(i);
      end
   end

   // The division computes round(2560 * d / den) with
   // d = 2 * isum - span * wsum and den = span * wsum, rounding ties away
   // from zero as floor((5120 * |d| + den) / (2 * den)).
   always_comb begin
      den  = lpc_pkg::den_type'(wsum_ff) * lpc_pkg::den_type'(lpc_pkg::SPAN);
      diff = lpc_pkg::diff_type'({isum_ff, 1'b0}) - lpc_pkg::diff_type'(den);
      mag  = diff[lpc_pkg::DIFF_W-1] ? lpc_pkg::den_type'(-diff)
                                     : lpc_pkg::den_type'(diff);
      div_in.rem  = lpc_pkg::rem_type'(mag) * lpc_pkg::rem_type'(lpc_pkg::POS_SCALE)
                    + lpc_pkg::rem_type'(den);
      div_in.dsr  = lpc_pkg::rem_type'({den, 1'b0}) << (lpc_pkg::Q_W - 1);
      div_in.quo  = '0;
      div_in.neg  = diff[lpc_pkg::DIFF_W-1];
      div_in.lost = (wsum_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wsum_ff <= wsum_in;
         isum_ff <= isum_in;
         div_ff  <= div_in;
      end
   end

   assign div_init = div_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpc_div_step.sv
// ----------------------------------------------------------------------------
// lpc_div_step
// One restoring division step: yields one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_div_step (
   input  wire logic             clock,
   input  wire logic             advance,
   input  wire lpc_pkg::div_type stage_prev,
   output lpc_pkg::div_type      stage_next
);

   lpc_pkg::div_type stage_ff, stage_in;
   logic             take;

   always_comb begin
      take           = (stage_prev.rem >= stage_prev.dsr);
      stage_in       = stage_prev;
      stage_in.rem   = take ? stage_prev.rem - stage_prev.dsr : stage_prev.rem;
      stage_in.quo   = {stage_prev.quo[lpc_pkg::Q_W-2:0], take};
      stage_in.dsr   = stage_prev.dsr >> 1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_next = stage_ff;

endmodule

`default_nettype wire

>>> rtl/core/line_position_centroid.sv
// ----------------------------------------------------------------------------
// line_position_centroid
// Weighted-centroid line position from an eight-sensor reflectance array.
// ----------------------------------------------------------------------------
//
//   Channel  Ports          Direction  Carries
//   req      req_valid/rdy  in         eight raw discharge times
//   rsp      rsp_valid/rdy  out        signed position (1/256 units), line_lost
//   csr      csr_valid/rdy  in         full_scale register
//
// The block accepts one item per cycle while the output is not stalled.
// Each item passes through one lane stage, one sum stage, one setup
// stage, twelve restoring division steps (one per quotient bit) and the
// output register. Reset is synchronous and clears the valid pipeline
// and sets full_scale to 2500. When the output register holds an item
// that is not taken, the whole pipeline holds, and req_ready drops in
// the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_centroid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lpc_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output lpc_pkg::rsp_item_type      rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire lpc_pkg::sample_type   csr_data
);

   // Valid bits for every stage, the last one being the output register.
   logic [lpc_pkg::PIPE_DEPTH-1:0] valid_ff, valid_in;
   assign valid_in = {valid_ff[lpc_pkg::PIPE_DEPTH-2:0], req_valid};

   // Every stage moves together whenever the output register is empty or its item is taken.
   logic advance;
   assign advance   = !valid_ff[lpc_pkg::PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   lpc_pkg::sample_type full_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         full_scale_ff <= lpc_pkg::FULL_SCALE_RESET;
      end else begin
         if (advance) begin
            valid_ff <= valid_in;
         end
         if (csr_valid) begin
            full_scale_ff <= csr_data;
         end
      end
   end

   // Lanes: each sensor is clamped and weighted by its own copy.
   lpc_pkg::sample_type [lpc_pkg::SENSOR_COUNT-1:0] weights;

   for (genvar g = 0; g < lpc_pkg::SENSOR_COUNT; g++) begin : g_lane
      lpc_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .full_scale (full_scale_ff),
         .sample     (lpc_pkg::sample_of(req_item, g)),
         .weight     (weights[g])
      );
   end

   // Merge: sums the lanes and prepares the dividend and divisor.
   lpc_pkg::div_type div_chain [lpc_pkg::Q_W+1];

   lpc_merge u_merge (
      .clock    (clock),
      .advance  (advance),
      .weights  (weights),
      .div_init (div_chain[0])
   );

   // Divider: one quotient bit per stage, most significant bit first.
   for (genvar k = 0; k < lpc_pkg::Q_W; k++) begin : g_div
      lpc_div_step u_step (
         .clock      (clock),
         .advance    (advance),
         .stage_prev (div_chain[k]),
         .stage_next (div_chain[k+1])
      );
   end

   // Output register: apply the sign, or force zero when the line is lost.
   lpc_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   lpc_pkg::pos_type      mag;

   always_comb begin
      mag                   = lpc_pkg::pos_type'({1'b0, div_chain[lpc_pkg::Q_W].quo});
      rsp_item_in.line_lost = div_chain[lpc_pkg::Q_W].lost;
      if (div_chain[lpc_pkg::Q_W].lost) begin
         rsp_item_in.position = '0;
      end else if (div_chain[lpc_pkg::Q_W].neg) begin
         rsp_item_in.position = -mag;
      end else begin
         rsp_item_in.position = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = valid_ff[lpc_pkg::PIPE_DEPTH-1];
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpc_checker.sv
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks for the line position centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpc_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire lpc_pkg::req_item_type req_item,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire lpc_pkg::rsp_item_type rsp_item,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire lpc_pkg::sample_type   csr_data
);

   logic unused_ok;
   assign unused_ok = req_valid ^ (^req_item) ^ csr_valid ^ (^csr_data);

   // A lost line always reports the center position.
   `ASSERT_IMPLIES(a_lost_center, clock, reset, rsp_valid && rsp_item.line_lost, rsp_item.position == '0, "line_lost with nonzero position")

   // The position stays within the -10.0 to +10.0 span.
   `ASSERT_IMPLIES(a_pos_range, clock, reset, rsp_valid, (rsp_item.position >= -13'sd2560) && (rsp_item.position <= 13'sd2560), "position out of range")

   // The input side stalls only while a result waits at the output.
   `ASSERT_ALWAYS(a_ready_rule, clock, reset, (req_ready == (!rsp_valid || rsp_ready)) && csr_ready, "ready does not follow output state")

   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "stalled result changed")

endmodule

bind line_position_centroid lpc_checker u_lpc_checker (.*);

`default_nettype wire
